@@ sv/lsd_decimal_radix_sort_assert.svh @@
// assertion macros for the decimal radix sort block
// used by the checker module, needs signals i_clk and i_rst_n in scope
`ifndef LSD_DECIMAL_RADIX_SORT_ASSERT_SVH
`define LSD_DECIMAL_RADIX_SORT_ASSERT_SVH

// same-cycle implication, off during reset
`define LSD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lsd assertion failed");

// next-cycle implication, off during reset
`define LSD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lsd assertion failed");

// next-cycle implication, checked through reset
`define LSD_ASSERT_NXT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("lsd assertion failed");

`endif

@@ sv/lsd_pkg.sv @@
// package of the decimal radix sort block: constants, types, power table
// no dependencies
package lsd_pkg;

    localparam int MAX_ITEMS_DEF = 64;
    localparam int RADIX         = 10;
    localparam int VAL_W         = 31;
    localparam int DIG_W         = 4;
    localparam int PASS_W        = 4;
    localparam int MAX_PASSES    = 10;
    localparam int PADDR_W       = 2;
    localparam int PDATA_W       = 32;
    localparam int RECIP_SHIFT   = 35;
    localparam logic [31:0] RECIP = 32'hCCCC_CCCD;

    localparam logic [PADDR_W-1:0] REG_DESCENDING = 2'd0;

    typedef enum logic [3:0] {
        S_LOAD,
        S_CHECK,
        S_COUNT,
        S_DRAIN_C,
        S_PREFIX,
        S_SCATTER,
        S_DRAIN_S,
        S_OUT_RD,
        S_OUT_WAIT,
        S_OUT_HOLD
    } t_state;

    typedef struct packed {
        logic load;
        logic blk_clear;
        logic clr_counts;
        logic issue_count;
        logic issue_scatter;
        logic prefix_step;
        logic swap;
        logic out_load;
        logic out_last;
    } t_cmd;

    typedef struct packed {
        logic pipe_busy;
        logic run_pass;
        logic out_valid;
    } t_sts;

    function automatic logic [VAL_W-1:0] pow10(input logic [PASS_W-1:0] p);
        logic [VAL_W-1:0] r;
        unique case (p)
            4'd0: r = 31'd1;
            4'd1: r = 31'd10;
            4'd2: r = 31'd100;
            4'd3: r = 31'd1000;
            4'd4: r = 31'd10000;
            4'd5: r = 31'd100000;
            4'd6: r = 31'd1000000;
            4'd7: r = 31'd10000000;
            4'd8: r = 31'd100000000;
            4'd9: r = 31'd1000000000;
            default: r = '1;
        endcase
        return r;
    endfunction

endpackage

@@ sv/lsd_if.sv @@
// word channel interfaces of the decimal radix sort block
// depends on lsd_pkg
interface lsd_in_if;
    logic                     valid;
    logic                     ready;
    logic [lsd_pkg::VAL_W-1:0] value;
    logic                     last;
    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface lsd_out_if;
    logic                     valid;
    logic                     ready;
    logic [lsd_pkg::VAL_W-1:0] value_res;
    logic                     last_res;
    modport source (output valid, output value_res, output last_res, input ready);
    modport sink   (input valid, input value_res, input last_res, output ready);
endinterface

@@ sv/lsd_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
module lsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ sv/lsd_ctrl.sv @@
// sequencer of the decimal radix sort: load, passes, output
// depends on lsd_pkg
module lsd_ctrl #(
    parameter int MAX_ITEMS = lsd_pkg::MAX_ITEMS_DEF,
    parameter int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1,
    parameter int CW = $clog2(MAX_ITEMS + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_last,
    output logic                        o_in_ready,
    input  lsd_pkg::t_sts               i_sts,
    input  logic [CW-1:0]               i_count,
    output lsd_pkg::t_cmd               o_cmd,
    output logic [AW-1:0]               o_addr,
    output logic [lsd_pkg::PASS_W-1:0]  o_pass,
    output logic [lsd_pkg::DIG_W-1:0]   o_bkt
);
    import lsd_pkg::*;

    t_state r_state, n_state;
    logic [CW-1:0]     r_idx, n_idx;
    logic [PASS_W-1:0] r_pass, n_pass;
    logic [DIG_W-1:0]  r_bkt, n_bkt;
    logic              idx_last;

    assign idx_last = (r_idx + CW'(1)) == i_count;
    assign o_addr   = r_idx[AW-1:0];
    assign o_pass   = r_pass;
    assign o_bkt    = r_bkt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_idx   <= '0;
            r_pass  <= '0;
            r_bkt   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_pass  <= n_pass;
            r_bkt   <= n_bkt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_pass     = r_pass;
        n_bkt      = r_bkt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_in_last) begin
                        n_pass  = '0;
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                n_idx = '0;
                if (i_sts.run_pass) begin
                    o_cmd.clr_counts = 1'b1;
                    n_state = S_COUNT;
                end else begin
                    n_state = S_OUT_RD;
                end
            end
            S_COUNT: begin
                o_cmd.issue_count = 1'b1;
                n_idx = r_idx + CW'(1);
                if (idx_last) begin
                    n_state = S_DRAIN_C;
                end
            end
            S_DRAIN_C: begin
                if (!i_sts.pipe_busy) begin
                    n_bkt   = '0;
                    n_state = S_PREFIX;
                end
            end
            S_PREFIX: begin
                o_cmd.prefix_step = 1'b1;
                n_bkt = r_bkt + DIG_W'(1);
                if (r_bkt == DIG_W'(RADIX - 1)) begin
                    n_idx   = '0;
                    n_state = S_SCATTER;
                end
            end
            S_SCATTER: begin
                o_cmd.issue_scatter = 1'b1;
                n_idx = r_idx + CW'(1);
                if (idx_last) begin
                    n_state = S_DRAIN_S;
                end
            end
            S_DRAIN_S: begin
                if (!i_sts.pipe_busy) begin
                    o_cmd.swap = 1'b1;
                    n_pass  = r_pass + PASS_W'(1);
                    n_state = S_CHECK;
                end
            end
            S_OUT_RD: begin
                n_state = S_OUT_WAIT;
            end
            S_OUT_WAIT: begin
                o_cmd.out_load = 1'b1;
                o_cmd.out_last = idx_last;
                n_state = S_OUT_HOLD;
            end
            S_OUT_HOLD: begin
                if (!i_sts.out_valid) begin
                    if (idx_last) begin
                        o_cmd.blk_clear = 1'b1;
                        n_state = S_LOAD;
                    end else begin
                        n_idx   = r_idx + CW'(1);
                        n_state = S_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end
endmodule

@@ sv/lsd_dp.sv @@
// datapath of the decimal radix sort: two ping-pong buffers, digit pipe,
// bucket counters and start pointers, output register; depends on lsd_pkg, lsd_ram
module lsd_dp #(
    parameter int MAX_ITEMS = lsd_pkg::MAX_ITEMS_DEF,
    parameter int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1,
    parameter int CW = $clog2(MAX_ITEMS + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lsd_pkg::t_cmd              i_cmd,
    output lsd_pkg::t_sts              o_sts,
    input  logic [AW-1:0]              i_addr,
    input  logic [lsd_pkg::PASS_W-1:0] i_pass,
    input  logic [lsd_pkg::DIG_W-1:0]  i_bkt,
    input  logic                       i_desc,
    input  logic [lsd_pkg::VAL_W-1:0]  i_value,
    input  logic                       i_out_ready,
    output logic [CW-1:0]              o_count,
    output logic                       o_out_valid,
    output logic [lsd_pkg::VAL_W-1:0]  o_out_value,
    output logic                       o_out_last
);
    import lsd_pkg::*;

    localparam int DW = 2 * VAL_W;

    logic [CW-1:0]    r_cnt;
    logic [VAL_W-1:0] r_largest;
    logic             r_sel;
    logic [CW-1:0]    r_bcnt  [RADIX];
    logic [CW-1:0]    r_start [RADIX];
    logic [CW-1:0]    r_pos;
    logic             r_v0, r_m0, r_v1, r_m1;
    logic [VAL_W-1:0] r_q1, r_qd, r_val1;
    logic             r_out_valid, r_out_last;
    logic [VAL_W-1:0] r_out_val;

    logic [DW-1:0]    a_rd, b_rd, src_rd, wr_data;
    logic             a_we, b_we, load_we, scat_we;
    logic [AW-1:0]    wr_addr;
    logic [VAL_W-1:0] src_q, quot, tens, diff;
    logic [63:0]      prod;
    logic [DIG_W-1:0] digit, bsel;

    // word layout: value in the upper half, running quotient in the lower
    assign src_rd = r_sel ? b_rd : a_rd;
    assign src_q  = src_rd[VAL_W-1:0];
    assign prod   = {33'd0, src_q} * {32'd0, RECIP};
    assign quot   = VAL_W'(prod >> RECIP_SHIFT);

    assign tens  = (r_qd << 3) + (r_qd << 1);
    assign diff  = r_q1 - tens;
    assign digit = diff[DIG_W-1:0];

    assign load_we = i_cmd.load && (r_cnt < CW'(MAX_ITEMS));
    assign scat_we = r_v1 && r_m1;
    assign a_we    = load_we || (scat_we && r_sel);
    assign b_we    = scat_we && !r_sel;
    assign wr_addr = load_we ? r_cnt[AW-1:0] : r_start[digit][AW-1:0];
    assign wr_data = load_we ? {i_value, i_value} : {r_val1, r_qd};

    assign bsel = i_desc ? (DIG_W'(RADIX - 1) - i_bkt) : i_bkt;

    lsd_ram #(.WIDTH(DW), .DEPTH(MAX_ITEMS), .AW(AW)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (i_addr),
        .o_rdata (a_rd)
    );

    lsd_ram #(.WIDTH(DW), .DEPTH(MAX_ITEMS), .AW(AW)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (i_addr),
        .o_rdata (b_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_largest   <= '0;
            r_sel       <= 1'b0;
            r_pos       <= '0;
            r_v0        <= 1'b0;
            r_m0        <= 1'b0;
            r_v1        <= 1'b0;
            r_m1        <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < RADIX; k++) begin
                r_bcnt[k]  <= '0;
                r_start[k] <= '0;
            end
        end else begin
            if (i_cmd.blk_clear) begin
                r_cnt     <= '0;
                r_largest <= '0;
                r_sel     <= 1'b0;
            end else if (load_we) begin
                r_cnt <= r_cnt + CW'(1);
                if (i_value > r_largest) begin
                    r_largest <= i_value;
                end
            end
            if (i_cmd.swap) begin
                r_sel <= !r_sel;
            end

            r_v0 <= i_cmd.issue_count || i_cmd.issue_scatter;
            r_m0 <= i_cmd.issue_scatter;
            r_v1 <= r_v0;
            r_m1 <= r_m0;

            if (i_cmd.clr_counts) begin
                r_pos <= '0;
                for (int k = 0; k < RADIX; k++) begin
                    r_bcnt[k] <= '0;
                end
            end else if (i_cmd.prefix_step) begin
                r_start[bsel] <= r_pos;
                r_pos         <= r_pos + r_bcnt[bsel];
            end else if (r_v1 && !r_m1) begin
                r_bcnt[digit] <= r_bcnt[digit] + CW'(1);
            end else if (scat_we) begin
                r_start[digit] <= r_start[digit] + CW'(1);
            end

            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q1   <= src_q;
        r_qd   <= quot;
        r_val1 <= src_rd[DW-1:VAL_W];
        if (i_cmd.out_load) begin
            r_out_val  <= src_rd[DW-1:VAL_W];
            r_out_last <= i_cmd.out_last;
        end
    end

    assign o_sts.pipe_busy = r_v0 || r_v1;
    assign o_sts.run_pass  = (i_pass < PASS_W'(MAX_PASSES)) && (r_largest >= pow10(i_pass));
    assign o_sts.out_valid = r_out_valid;
    assign o_count     = r_cnt;
    assign o_out_valid = r_out_valid;
    assign o_out_value = r_out_val;
    assign o_out_last  = r_out_last;
endmodule

@@ sv/lsd_decimal_radix_sort.sv @@
// top level of the decimal radix sort: apb register, sequencer, datapath
// depends on lsd_pkg, lsd_if, lsd_ctrl, lsd_dp
// load: one word per cycle in the load state; sort: per decimal digit of the largest
// value one pass (count sweep, 10-step prefix, scatter sweep over one ram port)
// output: the next word is read only once the last is taken; one block at a time
// reset: synchronous, clears control state and descending; buffers keep no reset
module lsd_decimal_radix_sort #(
    parameter int MAX_ITEMS = lsd_pkg::MAX_ITEMS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    lsd_in_if.sink                       i_in_w,
    lsd_out_if.source                    o_out_w,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lsd_pkg::PADDR_W-1:0]  paddr,
    input  logic [lsd_pkg::PDATA_W-1:0]  pwdata,
    output logic [lsd_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import lsd_pkg::*;

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);

    logic              r_desc;
    t_cmd              cmd;
    t_sts              sts;
    logic [AW-1:0]     addr;
    logic [PASS_W-1:0] pass;
    logic [DIG_W-1:0]  bkt;
    logic [CW-1:0]     count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_desc <= 1'b0;
        end else if (psel && penable && pwrite && (paddr == REG_DESCENDING)) begin
            r_desc <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == REG_DESCENDING) ? {{(PDATA_W-1){1'b0}}, r_desc} : '0;

    lsd_ctrl #(.MAX_ITEMS(MAX_ITEMS), .AW(AW), .CW(CW)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_w.valid),
        .i_in_last  (i_in_w.last),
        .o_in_ready (i_in_w.ready),
        .i_sts      (sts),
        .i_count    (count),
        .o_cmd      (cmd),
        .o_addr     (addr),
        .o_pass     (pass),
        .o_bkt      (bkt)
    );

    lsd_dp #(.MAX_ITEMS(MAX_ITEMS), .AW(AW), .CW(CW)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_addr      (addr),
        .i_pass      (pass),
        .i_bkt       (bkt),
        .i_desc      (r_desc),
        .i_value     (i_in_w.value),
        .i_out_ready (o_out_w.ready),
        .o_count     (count),
        .o_out_valid (o_out_w.valid),
        .o_out_value (o_out_w.value_res),
        .o_out_last  (o_out_w.last_res)
    );
endmodule

@@ sv/lsd_chk.sv @@
// port-level checker of the decimal radix sort, bound to the top level
// depends on lsd_pkg and lsd_decimal_radix_sort_assert.svh
module lsd_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [lsd_pkg::VAL_W-1:0]   i_out_value,
    input logic                        i_pready
);
`include "lsd_decimal_radix_sort_assert.svh"

    // a waiting word holds
    `LSD_ASSERT_NXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_value))
    // no word taken in while a result waits
    `LSD_ASSERT_IMP(a_no_load_in_out, i_out_valid, !i_in_ready)
    // ready to load right after reset
    `LSD_ASSERT_NXT_RST(a_ready_after_rst, !i_rst_n, i_in_ready && !i_out_valid)
    // apb never waits
    `LSD_ASSERT_IMP(a_pready, 1'b1, i_pready)
endmodule

bind lsd_decimal_radix_sort lsd_chk u_lsd_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_w.valid),
    .i_in_ready  (i_in_w.ready),
    .i_out_valid (o_out_w.valid),
    .i_out_ready (o_out_w.ready),
    .i_out_value (o_out_w.value_res),
    .i_pready    (pready)
);
